// ----- design/spherical_camera_ray_direction_assert.svh -----
// Assertion macros for the spherical camera ray direction block.
// Included by the top level; expects signals clk and rst in scope.
`ifndef SPHERICAL_CAMERA_RAY_DIRECTION_ASSERT_SVH
`define SPHERICAL_CAMERA_RAY_DIRECTION_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define SCRD_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("scrd assertion failed");

// Property that must hold a fixed number of cycles after its trigger.
`define SCRD_ASSERT_DELAY(lbl, cond, n, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (prop)) \
    else $error("scrd assertion failed");

`endif

// ----- design/scrd_pkg.sv -----
// Shared types and constants of the spherical camera ray direction block.
// No dependencies.
package scrd_pkg;

  localparam int NUM_W     = 48;
  localparam int FRAC_W    = 32;
  localparam int NQ_W      = NUM_W + FRAC_W;
  localparam int DIV_STEPS = NQ_W;
  localparam int DEN0_W    = 29;
  localparam int DEN_W     = 45;
  localparam int CW        = 34;
  localparam int ATAN_LEN  = 24;

  localparam logic [15:0] DEG_DIVISOR = 16'd46080;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [2:0] REG_HRES  = 3'd0;
  localparam logic [2:0] REG_VRES  = 3'd1;
  localparam logic [2:0] REG_PSIZE = 3'd2;
  localparam logic [2:0] REG_HHALF = 3'd3;
  localparam logic [2:0] REG_VHALF = 3'd4;
  localparam logic [2:0] REG_BU    = 3'd5;
  localparam logic [2:0] REG_BV    = 3'd6;
  localparam logic [2:0] REG_BW    = 3'd7;

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [NQ_W-1:0]  nq;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
  } div_lane_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] t;
    logic                 flip;
  } cordic_lane_t;

endpackage

// ----- design/scrd_div_cell.sv -----
// One restoring division step for the azimuth and elevation lanes.
// Depends on scrd_pkg.
module scrd_div_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  scrd_pkg::div_lane_t [1:0]    in_lane,
  output logic                         out_valid,
  output scrd_pkg::div_lane_t [1:0]    out_lane
);

  scrd_pkg::div_lane_t [1:0] lane_next;

  always_comb begin
    logic [scrd_pkg::DEN_W:0] rs;
    logic [scrd_pkg::DEN_W:0] diff;
    logic                     ge;
    for (int k = 0; k < 2; k++) begin
      rs   = {in_lane[k].r, in_lane[k].nq[scrd_pkg::NQ_W-1]};
      diff = rs - {1'b0, in_lane[k].den};
      ge   = rs >= {1'b0, in_lane[k].den};
      lane_next[k]    = in_lane[k];
      lane_next[k].r  = ge ? diff[scrd_pkg::DEN_W-1:0] : rs[scrd_pkg::DEN_W-1:0];
      lane_next[k].nq = {in_lane[k].nq[scrd_pkg::NQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule

// ----- design/scrd_cordic_cell.sv -----
// One CORDIC rotation for the azimuth and elevation lanes.
// Depends on scrd_pkg.
module scrd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  scrd_pkg::cordic_lane_t [1:0]  in_lane,
  output logic                          out_valid,
  output scrd_pkg::cordic_lane_t [1:0]  out_lane
);

  localparam logic signed [scrd_pkg::CW-1:0] ATAN =
    $signed({2'b00, scrd_pkg::ATAN_TURNS[STEP]});

  scrd_pkg::cordic_lane_t [1:0] lane_next;

  always_comb begin
    logic signed [scrd_pkg::CW-1:0] xs;
    logic signed [scrd_pkg::CW-1:0] ys;
    for (int k = 0; k < 2; k++) begin
      xs = in_lane[k].x >>> STEP;
      ys = in_lane[k].y >>> STEP;
      lane_next[k] = in_lane[k];
      if (!in_lane[k].t[scrd_pkg::CW-1]) begin
        lane_next[k].x = in_lane[k].x - ys;
        lane_next[k].y = in_lane[k].y + xs;
        lane_next[k].t = in_lane[k].t - ATAN;
      end else begin
        lane_next[k].x = in_lane[k].x + ys;
        lane_next[k].y = in_lane[k].y - xs;
        lane_next[k].t = in_lane[k].t + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule

// ----- design/spherical_camera_ray_direction.sv -----
// Top level of the spherical camera ray direction block: APB registers,
// operand setup, division and CORDIC cell rows, basis mixing. Uses scrd_pkg.
//
// channel  | handshake            | payload
// input    | start / busy         | view_x, view_y
// result   | done                 | dir_x, dir_y, dir_z
// config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A new word is taken every cycle; busy is always low.
// A result reaches the ports through the operand setup registers, the 80 division
// cells, the CORDIC start register, the CORDIC cells and the mixing registers.
// Reset clears the valid chain and restores the register defaults.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`include "spherical_camera_ray_direction_assert.svh"

module spherical_camera_ray_direction #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] view_x,
  input  logic signed [31:0] view_y,
  output logic               done,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int LATENCY = 2 + scrd_pkg::DIV_STEPS + 1 + CORDIC_STEPS + 4;

  logic [12:0] horiz_resolution;
  logic [12:0] vert_resolution;
  logic [15:0] pixel_size;
  logic [14:0] horiz_half_angle;
  logic [13:0] vert_half_angle;
  logic [47:0] basis_u;
  logic [47:0] basis_v;
  logic [47:0] basis_w;

  logic cfg_write;
  logic accept;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_resolution <= 13'd640;
      vert_resolution  <= 13'd480;
      pixel_size       <= 16'd4096;
      horiz_half_angle <= 15'd23040;
      vert_half_angle  <= 14'd11520;
      basis_u          <= 48'd16384;
      basis_v          <= 48'd1073741824;
      basis_w          <= 48'd70368744177664;
    end else if (cfg_write) begin
      case (paddr[5:3])
        scrd_pkg::REG_HRES:  horiz_resolution <= pwdata[12:0];
        scrd_pkg::REG_VRES:  vert_resolution  <= pwdata[12:0];
        scrd_pkg::REG_PSIZE: pixel_size       <= pwdata[15:0];
        scrd_pkg::REG_HHALF: horiz_half_angle <= pwdata[14:0];
        scrd_pkg::REG_VHALF: vert_half_angle  <= pwdata[13:0];
        scrd_pkg::REG_BU:    basis_u          <= pwdata[47:0];
        scrd_pkg::REG_BV:    basis_v          <= pwdata[47:0];
        scrd_pkg::REG_BW:    basis_w          <= pwdata[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      scrd_pkg::REG_HRES:  prdata = {51'd0, horiz_resolution};
      scrd_pkg::REG_VRES:  prdata = {51'd0, vert_resolution};
      scrd_pkg::REG_PSIZE: prdata = {48'd0, pixel_size};
      scrd_pkg::REG_HHALF: prdata = {49'd0, horiz_half_angle};
      scrd_pkg::REG_VHALF: prdata = {50'd0, vert_half_angle};
      scrd_pkg::REG_BU:    prdata = {16'd0, basis_u};
      scrd_pkg::REG_BV:    prdata = {16'd0, basis_v};
      scrd_pkg::REG_BW:    prdata = {16'd0, basis_w};
      default:             prdata = '0;
    endcase
  end

  // Operand setup: magnitudes, then numerator and divisor products.
  logic [31:0] coord [2];
  logic [12:0] res   [2];
  logic [14:0] half  [2];

  assign coord[0] = view_x;
  assign coord[1] = view_y;
  assign res[0]   = horiz_resolution;
  assign res[1]   = vert_resolution;
  assign half[0]  = horiz_half_angle;
  assign half[1]  = {1'b0, vert_half_angle};

  logic                        valid_a;
  logic [31:0]                 a_mag  [2];
  logic                        a_neg  [2];
  logic [scrd_pkg::DEN0_W-1:0] a_den0 [2];
  logic [14:0]                 a_half [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      a_neg[k]  <= coord[k][31];
      a_mag[k]  <= coord[k][31] ? (32'd0 - coord[k]) : coord[k];
      a_den0[k] <= pixel_size * res[k];
      a_half[k] <= half[k];
    end
  end

  logic                      div_v    [scrd_pkg::DIV_STEPS+1];
  scrd_pkg::div_lane_t [1:0] div_lane [scrd_pkg::DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else begin
      div_v[0] <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    logic [46:0] prod;
    logic [44:0] den;
    for (int k = 0; k < 2; k++) begin
      prod = a_mag[k] * a_half[k];
      den  = a_den0[k] * scrd_pkg::DEG_DIVISOR;
      div_lane[0][k].r    <= '0;
      div_lane[0][k].nq   <= {prod, 1'b0, {scrd_pkg::FRAC_W{1'b0}}};
      div_lane[0][k].den  <= den[scrd_pkg::DEN_W-1:0];
      div_lane[0][k].neg  <= a_neg[k];
      div_lane[0][k].zero <= a_den0[k] == '0;
    end
  end

  for (genvar i = 0; i < scrd_pkg::DIV_STEPS; i++) begin : g_div
    scrd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_v[i]),
      .in_lane   (div_lane[i]),
      .out_valid (div_v[i+1]),
      .out_lane  (div_lane[i+1])
    );
  end

  // Binary angle, quadrant fold, CORDIC start vector.
  logic                         cor_v    [CORDIC_STEPS+1];
  scrd_pkg::cordic_lane_t [1:0] cor_lane [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_v[0] <= 1'b0;
    end else begin
      cor_v[0] <= div_v[scrd_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0]                    q;
    logic [31:0]                    ang;
    logic signed [scrd_pkg::CW-1:0] ts;
    for (int k = 0; k < 2; k++) begin
      q   = div_lane[scrd_pkg::DIV_STEPS][k].nq[scrd_pkg::FRAC_W-1:0];
      ang = div_lane[scrd_pkg::DIV_STEPS][k].zero ? 32'd0 :
            div_lane[scrd_pkg::DIV_STEPS][k].neg ? (32'd0 - q) : q;
      ts  = {{(scrd_pkg::CW-32){ang[31]}}, ang};
      cor_lane[0][k].x <= scrd_pkg::CORDIC_GAIN;
      cor_lane[0][k].y <= '0;
      if (ts > 34'sh040000000) begin
        cor_lane[0][k].t    <= ts - 34'sh080000000;
        cor_lane[0][k].flip <= 1'b1;
      end else if (ts < -34'sh040000000) begin
        cor_lane[0][k].t    <= ts + 34'sh080000000;
        cor_lane[0][k].flip <= 1'b1;
      end else begin
        cor_lane[0][k].t    <= ts;
        cor_lane[0][k].flip <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    scrd_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cor_v[i]),
      .in_lane   (cor_lane[i]),
      .out_valid (cor_v[i+1]),
      .out_lane  (cor_lane[i+1])
    );
  end

  // Angle products and basis mixing.
  scrd_pkg::cordic_lane_t az_end;
  scrd_pkg::cordic_lane_t el_end;
  logic signed [scrd_pkg::CW-1:0] sa_w, ca_w, se_w, ce_w;

  assign az_end = cor_lane[CORDIC_STEPS][0];
  assign el_end = cor_lane[CORDIC_STEPS][1];
  assign sa_w   = az_end.flip ? -az_end.y : az_end.y;
  assign ca_w   = az_end.flip ? -az_end.x : az_end.x;
  assign se_w   = el_end.flip ? -el_end.y : el_end.y;
  assign ce_w   = el_end.flip ? -el_end.x : el_end.x;

  logic               valid_m1, valid_m2, valid_m3;
  logic signed [63:0] m1_pa, m1_pc;
  logic signed [31:0] m1_se;
  logic signed [32:0] m2_a, m2_c, m2_se;
  logic signed [48:0] m3_prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m1 <= 1'b0;
      valid_m2 <= 1'b0;
      valid_m3 <= 1'b0;
      done     <= 1'b0;
    end else begin
      valid_m1 <= cor_v[CORDIC_STEPS];
      valid_m2 <= valid_m1;
      valid_m3 <= valid_m2;
      done     <= valid_m3;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] ra;
    logic signed [63:0] rc;
    logic signed [32:0] cr;
    m1_pa <= $signed(ce_w[31:0]) * $signed(sa_w[31:0]);
    m1_pc <= $signed(ce_w[31:0]) * $signed(ca_w[31:0]);
    m1_se <= se_w[31:0];
    ra    = m1_pa + 64'sd536870912;
    rc    = m1_pc + 64'sd536870912;
    cr    = rc[62:30];
    m2_a  <= ra[62:30];
    m2_c  <= -cr;
    m2_se <= {m1_se[31], m1_se};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m3_prod[k][0] <= m2_a  * $signed(basis_u[16*k +: 16]);
      m3_prod[k][1] <= m2_se * $signed(basis_v[16*k +: 16]);
      m3_prod[k][2] <= m2_c  * $signed(basis_w[16*k +: 16]);
    end
  end

  logic signed [15:0] comp [3];

  always_comb begin
    logic signed [50:0] acc;
    logic signed [50:0] rnd;
    logic signed [20:0] r;
    for (int k = 0; k < 3; k++) begin
      acc = 51'(m3_prod[k][0]) + 51'(m3_prod[k][1]) + 51'(m3_prod[k][2]);
      rnd = acc + 51'sd536870912;
      r   = rnd[50:30];
      if (r > 21'sd32767) begin
        comp[k] = 16'sh7fff;
      end else if (r < -21'sd32768) begin
        comp[k] = 16'sh8000;
      end else begin
        comp[k] = r[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    dir_x <= comp[0];
    dir_y <= comp[1];
    dir_z <= comp[2];
  end

  `SCRD_ASSERT_DELAY(a_latency, accept, LATENCY, done)
  `SCRD_ASSERT_DELAY(a_cordic_row, cor_v[0], CORDIC_STEPS, cor_v[CORDIC_STEPS])
  `SCRD_ASSERT_DELAY(a_div_row, div_v[0], scrd_pkg::DIV_STEPS, div_v[scrd_pkg::DIV_STEPS])

endmodule

// ----- test/ray_direction_checker.sv -----
// Checker for the spherical camera ray direction block: mirrors the register
// writes, predicts each ray direction and compares the results. Uses scrd_pkg.
module ray_direction_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] view_x,
  input  logic signed [31:0] view_y,
  input  logic               done,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ray_dir_t;

  ray_dir_t dir_queue[$];
  longint unsigned hres, vres, psize, hhalf, vhalf;
  logic [47:0] bu, bv, bw;

  assign pending = dir_queue.size();

  function automatic logic [31:0] turn_angle(logic [31:0] coord, longint unsigned res,
                                             longint unsigned half);
    logic neg;
    longint unsigned mag, num, den, r;
    logic [31:0] q;
    neg = coord[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, coord}) : {32'd0, coord};
    num = 2 * mag * half;
    den = psize * res * scrd_pkg::DEG_DIVISOR;
    if (den == 0) return 32'd0;
    r = num % den;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint s,
                                 output longint c);
    longint t, x, y, nx;
    logic flip;
    t = longint'({32'd0, ang});
    x = longint'(scrd_pkg::CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (t >= 64'sh8000_0000) t = t - 64'sh1_0000_0000;
    if (t > 64'sh4000_0000) begin
      t = t - 64'sh8000_0000;
      flip = 1'b1;
    end else if (t < -64'sh4000_0000) begin
      t = t + 64'sh8000_0000;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < scrd_pkg::ATAN_LEN; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        t = t - longint'({32'd0, scrd_pkg::ATAN_TURNS[i]});
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        t = t + longint'({32'd0, scrd_pkg::ATAN_TURNS[i]});
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] mix(longint a, longint b, longint c, int sh);
    longint acc, r;
    acc = a * longint'($signed(bu[sh +: 16])) + b * longint'($signed(bv[sh +: 16]))
        + c * longint'($signed(bw[sh +: 16]));
    r = (acc + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic ray_dir_t predict_dir(logic [31:0] vx, logic [31:0] vy);
    longint sa, ca, se, ce, a, c;
    ray_dir_t d;
    rotate(turn_angle(vx, hres, hhalf), sa, ca);
    rotate(turn_angle(vy, vres, vhalf), se, ce);
    a = (ce * sa + (64'sd1 <<< 29)) >>> 30;
    c = -((ce * ca + (64'sd1 <<< 29)) >>> 30);
    d.x = mix(a, se, c, 0);
    d.y = mix(a, se, c, 16);
    d.z = mix(a, se, c, 32);
    return d;
  endfunction

  always @(posedge clk) begin
    ray_dir_t e;
    if (rst) begin
      hres <= 640;
      vres <= 480;
      psize <= 4096;
      hhalf <= 23040;
      vhalf <= 11520;
      bu <= 48'd16384;
      bv <= 48'd1073741824;
      bw <= 48'd70368744177664;
      dir_queue.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          scrd_pkg::REG_HRES:  hres <= pwdata[12:0];
          scrd_pkg::REG_VRES:  vres <= pwdata[12:0];
          scrd_pkg::REG_PSIZE: psize <= pwdata[15:0];
          scrd_pkg::REG_HHALF: hhalf <= pwdata[14:0];
          scrd_pkg::REG_VHALF: vhalf <= pwdata[13:0];
          scrd_pkg::REG_BU:    bu <= pwdata[47:0];
          scrd_pkg::REG_BV:    bv <= pwdata[47:0];
          scrd_pkg::REG_BW:    bw <= pwdata[47:0];
          default: ;
        endcase
      end
      if (start && !busy) dir_queue.push_back(predict_dir(view_x, view_y));
      if (done) begin
        if (dir_queue.size() == 0) begin
          $display("%0t: unexpected word %0d %0d %0d", $time, dir_x, dir_y, dir_z);
          errors <= errors + 1;
        end else begin
          e = dir_queue.pop_front();
          if (e.x !== dir_x || e.y !== dir_y || e.z !== dir_z) begin
            $display("%0t: expected %0d %0d %0d, actual %0d %0d %0d", $time,
                     e.x, e.y, e.z, dir_x, dir_y, dir_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/spherical_camera_ray_direction_tb.sv -----
// Testbench top for the spherical camera ray direction block: drives view
// points and register writes through several settings and idle phases.
// Depends on scrd_pkg, the block and ray_direction_checker.
module spherical_camera_ray_direction_tb;

  logic clk, rst, start, busy, done, psel, penable, pwrite, pready;
  logic signed [31:0] view_x, view_y;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  int errors, pending;
  int idle_pct;

  spherical_camera_ray_direction dut (.*);
  ray_direction_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    view_x <= x;
    view_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_burst(input int n, input longint unsigned span_x,
                            input longint unsigned span_y);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = $urandom;
      y = $urandom;
      if ($urandom_range(9) < 7) begin
        x = $urandom_range(span_x + 1) - (span_x + 1) / 2;
        y = $urandom_range(span_y + 1) - (span_y + 1) / 2;
      end
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
      start <= 1'b1;
      view_x <= x;
      view_y <= y;
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  initial begin
    logic [31:0] pts [10];
    longint unsigned hr, vr, ps;
    int idle_modes [4];
    rst = 1'b1;
    start = 1'b0;
    view_x = '0;
    view_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    idle_modes = '{0, 73, 20, 0};
    pts = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
            32'd1310720, -32'sd1310720, 32'd983040, -32'sd655360, 32'd327680};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 10; i++) send_point(pts[i], pts[9 - i]);
    drain();
    write_reg(scrd_pkg::REG_PSIZE, 64'd0);
    send_point(32'd40960, 32'd40960);
    drain();
    write_reg(scrd_pkg::REG_PSIZE, 64'd65535);
    write_reg(scrd_pkg::REG_HRES, 64'd4096);
    write_reg(scrd_pkg::REG_VRES, 64'd4096);
    write_reg(scrd_pkg::REG_HHALF, 64'd0);
    write_reg(scrd_pkg::REG_VHALF, 64'd0);
    write_reg(scrd_pkg::REG_BU, 64'hFFFF_FFFF_FFFF);
    write_reg(scrd_pkg::REG_BV, 64'h8000_8000_8000);
    write_reg(scrd_pkg::REG_BW, 64'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 5; i++) send_point(pts[i], pts[i + 5]);
    drain();
    write_reg(scrd_pkg::REG_HHALF, 64'd32767);
    write_reg(scrd_pkg::REG_VHALF, 64'd16383);
    write_reg(scrd_pkg::REG_HRES, 64'd1);
    write_reg(scrd_pkg::REG_VRES, 64'd1);
    write_reg(scrd_pkg::REG_PSIZE, 64'd1);
    for (int i = 0; i < 8; i++) send_point(pts[i], pts[i + 2]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idle_modes[ph % 4];
      hr = (ph == 3) ? 4096 : $urandom_range(4096, 1);
      vr = (ph == 5) ? 4096 : $urandom_range(4096, 1);
      ps = (ph == 3) ? 65535 : $urandom_range(65535, 1);
      write_reg(scrd_pkg::REG_HRES, hr);
      write_reg(scrd_pkg::REG_VRES, vr);
      write_reg(scrd_pkg::REG_PSIZE, ps);
      write_reg(scrd_pkg::REG_HHALF, (ph == 2) ? 23040 : $urandom_range(23040));
      write_reg(scrd_pkg::REG_VHALF, (ph == 2) ? 11520 : $urandom_range(11520));
      write_reg(scrd_pkg::REG_BU, {$urandom, $urandom});
      write_reg(scrd_pkg::REG_BV, {$urandom, $urandom});
      write_reg(scrd_pkg::REG_BW, {$urandom, $urandom});
      send_burst(200, ps * hr / 2, ps * vr / 2);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
